[design/rwc_pkg.sv]
// Shared types, constants and the saturating accumulate for the ring winding classifier.
// Used by rwc_classify and ring_winding_classifier; depends on nothing else.
package rwc_pkg;

    localparam int COORD_W = 16;
    localparam int OPND_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * OPND_W;
    localparam int AREA_W  = 50;

    typedef enum logic [1:0] {
        ACT_DROP = 2'd0,
        ACT_HOLE = 2'd1,
        ACT_NEW  = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        WIND_NEG  = 2'd0,
        WIND_POS  = 2'd1,
        WIND_ZERO = 2'd2
    } winding_t;

    typedef enum logic [1:0] {
        REF_NONE = 2'd0,
        REF_NEG  = 2'd1,
        REF_POS  = 2'd2
    } ref_wind_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      last_in_ring;
        logic                      last_ring_of_feature;
    } in_t;

    typedef struct packed {
        logic signed [AREA_W-1:0] ring_area;
        action_t                  action;
        winding_t                 winding;
    } out_t;

    // Add a product term to the running sum, clamping to the signed area range
    function automatic logic signed [AREA_W-1:0] sat_add(
        input logic signed [AREA_W-1:0] acc,
        input logic signed [PROD_W-1:0] term
    );
        logic signed [AREA_W:0] s;
        logic signed [AREA_W-1:0] r;
        s = {acc[AREA_W-1], acc} + {{(AREA_W + 1 - PROD_W){term[PROD_W-1]}}, term};
        if (s[AREA_W] != s[AREA_W-1])
        begin
            r = s[AREA_W] ? {1'b1, {(AREA_W-1){1'b0}}} : {1'b0, {(AREA_W-1){1'b1}}};
        end
        else
        begin
            r = s[AREA_W-1:0];
        end
        return r;
    endfunction

endpackage

[design/rwc_classify.sv]
// Ring classification: winding sign, drop / hole / new-polygon decision and per-feature state.
// Depends on rwc_pkg.
module rwc_classify (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             fire,
    input  logic signed [rwc_pkg::AREA_W-1:0] area,
    input  logic                             last_ring_of_feature,
    output rwc_pkg::action_t                 action,
    output rwc_pkg::winding_t                winding
);

    logic                feature_start_reg;
    logic                feature_start_next;
    rwc_pkg::ref_wind_t  ref_reg;
    rwc_pkg::ref_wind_t  ref_next;
    logic                poly_open_reg;
    logic                poly_open_next;

    logic                area_zero;
    rwc_pkg::ref_wind_t  ring_ref;
    rwc_pkg::ref_wind_t  ref_eff;
    logic                single_ring;

    // Decode sign of the finished ring and choose its action
    always_comb
    begin
        area_zero   = (area == '0);
        ring_ref    = area[rwc_pkg::AREA_W-1] ? rwc_pkg::REF_NEG : rwc_pkg::REF_POS;
        ref_eff     = (ref_reg == rwc_pkg::REF_NONE) ? ring_ref : ref_reg;
        single_ring = feature_start_reg && last_ring_of_feature;

        if (area_zero)
        begin
            winding = rwc_pkg::WIND_ZERO;
        end
        else if (area[rwc_pkg::AREA_W-1])
        begin
            winding = rwc_pkg::WIND_NEG;
        end
        else
        begin
            winding = rwc_pkg::WIND_POS;
        end

        if (single_ring)
        begin
            action = rwc_pkg::ACT_NEW;
        end
        else if (area_zero)
        begin
            action = rwc_pkg::ACT_DROP;
        end
        else if ((ring_ref == ref_eff) || !poly_open_reg)
        begin
            action = rwc_pkg::ACT_NEW;
        end
        else
        begin
            action = rwc_pkg::ACT_HOLE;
        end
    end

    // Advance feature state on each finished ring
    always_comb
    begin
        feature_start_next = feature_start_reg;
        ref_next           = ref_reg;
        poly_open_next     = poly_open_reg;
        if (fire)
        begin
            if (!single_ring && !area_zero)
            begin
                ref_next       = ref_eff;
                poly_open_next = 1'b1;
            end
            if (last_ring_of_feature)
            begin
                feature_start_next = 1'b1;
                ref_next           = rwc_pkg::REF_NONE;
                poly_open_next     = 1'b0;
            end
            else
            begin
                feature_start_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feature_start_reg <= 1'b1;
            ref_reg           <= rwc_pkg::REF_NONE;
            poly_open_reg     <= 1'b0;
        end
        else
        begin
            feature_start_reg <= feature_start_next;
            ref_reg           <= ref_next;
            poly_open_reg     <= poly_open_next;
        end
    end

endmodule

[design/ring_winding_classifier.sv]
// Shoelace ring area and winding classifier. A ring's result passes the operand, product and
// accumulate registers, then the result register, after its last vertex is accepted.
// Throughput: one vertex per cycle when the output is not stalled; the 50-bit saturating
// accumulate is the only recurrence. Vertices that end no ring pass without producing a result.
// Reset: asynchronous, active low; empties the pipeline, next vertex starts a ring and a feature.
// Depends on rwc_pkg and rwc_classify.
module ring_winding_classifier (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  rwc_pkg::in_t   in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output rwc_pkg::out_t  out_data
);

    localparam int OW = rwc_pkg::OPND_W;
    localparam int PW = rwc_pkg::PROD_W;
    localparam int AW = rwc_pkg::AREA_W;
    localparam int CW = rwc_pkg::COORD_W;

    // Ring tracking at the input
    logic          ring_start_reg;
    logic [CW-1:0] first_x_reg;
    logic [CW-1:0] first_y_reg;
    logic [CW-1:0] prev_x_reg;
    logic [CW-1:0] prev_y_reg;

    // Stage 1: operands
    logic                 v1_reg;
    logic signed [OW-1:0] edx_reg;
    logic signed [OW-1:0] esy_reg;
    logic signed [OW-1:0] cdx_reg;
    logic signed [OW-1:0] csy_reg;
    logic                 rs1_reg;
    logic                 last1_reg;
    logic                 feat1_reg;

    // Stage 2: products
    logic                 v2_reg;
    logic signed [PW-1:0] pe_reg;
    logic signed [PW-1:0] pc2_reg;
    logic                 rs2_reg;
    logic                 last2_reg;
    logic                 feat2_reg;

    // Stage 3: running sum
    logic                 v3_reg;
    logic signed [AW-1:0] area_sum_reg;
    logic signed [AW-1:0] area_sum_next;
    logic signed [PW-1:0] pc3_reg;
    logic                 last3_reg;
    logic                 feat3_reg;

    // Result register
    logic                 out_valid_reg;
    rwc_pkg::out_t        out_data_reg;

    logic                 accept;
    logic                 go1;
    logic                 go2;
    logic                 go3;
    logic                 emit;
    logic [CW-1:0]        fx_eff;
    logic [CW-1:0]        fy_eff;
    logic signed [AW-1:0] ring_area;
    rwc_pkg::action_t     action;
    rwc_pkg::winding_t    winding;

    // Move stages forward whenever the next one is empty or moving
    always_comb
    begin
        emit     = v3_reg && last3_reg;
        go3      = v3_reg && (!last3_reg || !out_valid_reg || out_ready);
        go2      = v2_reg && (!v3_reg || go3);
        go1      = v1_reg && (!v2_reg || go2);
        in_ready = !v1_reg || go1;
        accept   = in_valid && in_ready;
    end

    // Select closing vertex: a one-vertex ring closes on itself
    always_comb
    begin
        fx_eff = ring_start_reg ? in_data.x : first_x_reg;
        fy_eff = ring_start_reg ? in_data.y : first_y_reg;
    end

    // Hold ring start and previous vertex per transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_start_reg <= 1'b1;
        end
        else if (accept)
        begin
            ring_start_reg <= in_data.last_in_ring;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (ring_start_reg)
            begin
                first_x_reg <= in_data.x;
                first_y_reg <= in_data.y;
            end
            prev_x_reg <= in_data.x;
            prev_y_reg <= in_data.y;
        end
    end

    // Stage 1: edge and closing-edge operands
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            v1_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            edx_reg   <= {prev_x_reg[CW-1], prev_x_reg} - {in_data.x[CW-1], in_data.x};
            esy_reg   <= {in_data.y[CW-1], in_data.y} + {prev_y_reg[CW-1], prev_y_reg};
            cdx_reg   <= {in_data.x[CW-1], in_data.x} - {fx_eff[CW-1], fx_eff};
            csy_reg   <= {fy_eff[CW-1], fy_eff} + {in_data.y[CW-1], in_data.y};
            rs1_reg   <= ring_start_reg;
            last1_reg <= in_data.last_in_ring;
            feat1_reg <= in_data.last_ring_of_feature;
        end
    end

    // Stage 2: multiply
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (!v2_reg || go2)
        begin
            v2_reg <= go1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go1 && (!v2_reg || go2))
        begin
            pe_reg    <= edx_reg * esy_reg;
            pc2_reg   <= cdx_reg * csy_reg;
            rs2_reg   <= rs1_reg;
            last2_reg <= last1_reg;
            feat2_reg <= feat1_reg;
        end
    end

    // Stage 3: saturating accumulate, cleared at ring start
    always_comb
    begin
        area_sum_next = rs2_reg ? '0 : rwc_pkg::sat_add(area_sum_reg, pe_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (!v3_reg || go3)
        begin
            v3_reg <= go2;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go2 && (!v3_reg || go3))
        begin
            area_sum_reg <= area_sum_next;
            pc3_reg      <= pc2_reg;
            last3_reg    <= last2_reg;
            feat3_reg    <= feat2_reg;
        end
    end

    // Close the ring and classify it
    always_comb
    begin
        ring_area = rwc_pkg::sat_add(area_sum_reg, pc3_reg);
    end

    rwc_classify u_classify (
        .clk                  (clk),
        .rst_n                (rst_n),
        .fire                 (go3 && emit),
        .area                 (ring_area),
        .last_ring_of_feature (feat3_reg),
        .action               (action),
        .winding              (winding)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (go3 && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go3 && emit)
        begin
            out_data_reg.ring_area <= ring_area;
            out_data_reg.action    <= action;
            out_data_reg.winding   <= winding;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for ring_winding_classifier: streams ring vertices, predicts
// each finished ring's area, action and winding, and compares them with the block's results.
// Depends on rwc_pkg and the ring_winding_classifier RTL.
module tb_top;

    localparam longint AREA_TOP    = 64'sh0001_FFFF_FFFF_FFFF;
    localparam longint AREA_BOTTOM = -AREA_TOP - 1;
    localparam int     CORNER_ROUNDS = 4;
    localparam int     RANDOM_ITEMS = 700;
    localparam int     DRAIN_LIMIT = 5000;

    // Predict ring results from accepted vertices and match them against the block
    class ring_area_tracker;
        rwc_pkg::out_t                      rings_due[$];
        int                                 errors;
        int                                 rings_seen;
        logic signed [rwc_pkg::COORD_W-1:0] first_x, first_y, prev_x, prev_y;
        longint                             area_sum;
        bit                                 ring_start, feature_start, polygon_open;
        rwc_pkg::ref_wind_t                 ref_wind;

        function new();
            errors        = 0;
            rings_seen    = 0;
            first_x       = '0;
            first_y       = '0;
            prev_x        = '0;
            prev_y        = '0;
            area_sum      = 0;
            ring_start    = 1'b1;
            feature_start = 1'b1;
            polygon_open  = 1'b0;
            ref_wind      = rwc_pkg::REF_NONE;
        endfunction

        function longint clamp_area(longint s);
            if (s > AREA_TOP)
                return AREA_TOP;
            if (s < AREA_BOTTOM)
                return AREA_BOTTOM;
            return s;
        endfunction

        function int pending();
            return rings_due.size();
        endfunction

        task note_mismatch(string what);
            errors++;
            $display("MISMATCH: %s", what);
        endtask

        // Advance the shoelace sum; classify the ring on its closing vertex
        function void take_vertex(rwc_pkg::in_t v);
            longint             cx, cy, fx, fy, px, py, area;
            rwc_pkg::winding_t  wind;
            rwc_pkg::action_t   act;
            rwc_pkg::ref_wind_t w;
            rwc_pkg::out_t      r;
            cx = $signed(v.x);
            cy = $signed(v.y);
            if (ring_start)
            begin
                first_x  = v.x;
                first_y  = v.y;
                area_sum = 0;
            end
            else
            begin
                px = $signed(prev_x);
                py = $signed(prev_y);
                area_sum = clamp_area(area_sum + (px - cx) * (cy + py));
            end
            prev_x     = v.x;
            prev_y     = v.y;
            ring_start = 1'b0;
            if (!v.last_in_ring)
                return;

            // Close the ring back to its first vertex
            fx   = $signed(first_x);
            fy   = $signed(first_y);
            area = clamp_area(area_sum + (cx - fx) * (fy + cy));
            wind = (area == 0) ? rwc_pkg::WIND_ZERO :
                   ((area < 0) ? rwc_pkg::WIND_NEG : rwc_pkg::WIND_POS);

            if (feature_start && v.last_ring_of_feature)
                act = rwc_pkg::ACT_NEW;
            else if (area == 0)
                act = rwc_pkg::ACT_DROP;
            else
            begin
                w = (wind == rwc_pkg::WIND_NEG) ? rwc_pkg::REF_NEG : rwc_pkg::REF_POS;
                if (ref_wind == rwc_pkg::REF_NONE)
                    ref_wind = w;
                act = (w == ref_wind || !polygon_open) ? rwc_pkg::ACT_NEW : rwc_pkg::ACT_HOLE;
                polygon_open = 1'b1;
            end

            r.ring_area = area[rwc_pkg::AREA_W-1:0];
            r.action    = act;
            r.winding   = wind;
            rings_due.insert(rings_due.size(), r);

            ring_start = 1'b1;
            area_sum   = 0;
            if (v.last_ring_of_feature)
            begin
                feature_start = 1'b1;
                ref_wind      = rwc_pkg::REF_NONE;
                polygon_open  = 1'b0;
            end
            else
                feature_start = 1'b0;
        endfunction

        // Compare one result transaction with the oldest predicted ring
        task match_ring(rwc_pkg::out_t got);
            rwc_pkg::out_t want;
            if (rings_due.size() == 0)
            begin
                note_mismatch($sformatf("result with no ring pending, area %0d",
                                        $signed(got.ring_area)));
                return;
            end
            want = rings_due.pop_front();
            if (got.ring_area !== want.ring_area)
                note_mismatch($sformatf("ring %0d area %0d, want %0d", rings_seen,
                                        $signed(got.ring_area), $signed(want.ring_area)));
            if (got.action !== want.action)
                note_mismatch($sformatf("ring %0d action %0d, want %0d", rings_seen,
                                        got.action, want.action));
            if (got.winding !== want.winding)
                note_mismatch($sformatf("ring %0d winding %0d, want %0d", rings_seen,
                                        got.winding, want.winding));
            rings_seen++;
        endtask
    endclass

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           in_valid  = 1'b0;
    logic           in_ready;
    rwc_pkg::in_t   in_data   = '0;
    logic           out_valid;
    logic           out_ready = 1'b0;
    rwc_pkg::out_t  out_data;

    ring_area_tracker board = new();
    bit    no_idle      = 1'b0;
    bit    hold_req     = 1'b0;
    int    vertex_count = 0;

    ring_winding_classifier dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #4 clk = ~clk;

    // Offer one vertex; returns on the edge that accepts it
    task automatic offer_vertex(input int x, input int y, input bit lir, input bit lrf);
        rwc_pkg::in_t v;
        v.x                    = x[rwc_pkg::COORD_W-1:0];
        v.y                    = y[rwc_pkg::COORD_W-1:0];
        v.last_in_ring         = lir;
        v.last_ring_of_feature = lrf;
        while (!no_idle && $urandom_range(99) < 17)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= v;
        do
            @(negedge clk);
        while (!in_ready);
        board.take_vertex(v);
        vertex_count++;
        @(posedge clk);
    endtask

    function automatic logic signed [rwc_pkg::COORD_W-1:0] pick_coord();
        int k;
        int v;
        k = $urandom_range(9);
        if (k == 0)
        begin
            case ($urandom_range(3))
                0:       v = -32768;
                1:       v = 32767;
                2:       v = 0;
                default: v = -1;
            endcase
        end
        else if (k < 4)
            v = $urandom_range(127) - 64;
        else
            v = $urandom_range(65535);
        return v[rwc_pkg::COORD_W-1:0];
    endfunction

    // Walk the four extreme corners a few rounds for the largest edge terms,
    // then turn back a few rounds so the sum shrinks again
    task automatic corner_ring(input bit positive, input bit lrf);
        int  c;
        int  x;
        int  y;
        bit  forward;
        bit  last;
        for (int r = 0; r < CORNER_ROUNDS + 3; r++)
        begin
            forward = (r < CORNER_ROUNDS) ? positive : !positive;
            for (int k = 0; k < 4; k++)
            begin
                c    = forward ? k : (4 - k) % 4;
                x    = (c == 0 || c == 3) ? 32767 : -32768;
                y    = (c < 2) ? 32767 : -32768;
                last = (r == CORNER_ROUNDS + 2) && (k == 3);
                offer_vertex(x, y, last, lrf);
            end
        end
    endtask

    // Emit one feature: mostly well-formed rings, now and then a stream of loose flags
    task automatic random_feature();
        int  rings;
        int  n;
        int  k;
        int  fy;
        bit  flat;
        bit  last_ring;
        bit  lrf;
        if ($urandom_range(9) == 0)
        begin
            n = $urandom_range(2, 12);
            for (int i = 0; i < n; i++)
                offer_vertex(pick_coord(), pick_coord(), $urandom_range(3) == 0,
                             $urandom_range(1) == 1);
            return;
        end
        rings = $urandom_range(1, 4);
        for (int r = 0; r < rings; r++)
        begin
            last_ring = (r == rings - 1);
            k = $urandom_range(19);
            if (k == 0)
                n = 1;
            else if (k == 1)
                n = 2;
            else if (k == 2)
                n = $urandom_range(20, 40);
            else
                n = $urandom_range(3, 8);
            // constant y gives a degenerate ring of zero area
            flat = ($urandom_range(9) == 0);
            fy   = pick_coord();
            for (int i = 0; i < n; i++)
            begin
                if (i == n - 1 || $urandom_range(4) != 0)
                    lrf = last_ring;
                else
                    lrf = !last_ring;
                offer_vertex(pick_coord(), flat ? fy : pick_coord(), i == n - 1, lrf);
            end
        end
    endtask

    // Result side: random stalls, one long hold-off on request
    initial
    begin : result_sink
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                hold_left = 400;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (!no_idle && $urandom_range(99) < 17)
                out_ready <= 1'b0;
            else
                out_ready <= 1'b1;
            @(negedge clk);
            if (out_valid && out_ready)
                board.match_ring(out_data);
            @(posedge clk);
        end
    end

    // Stimulus and end of run
    initial
    begin : stimulus
        int  waited;
        bit  paused;
        paused = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single vertex alone in its feature: zero area, still begins a polygon
        offer_vertex(0, 0, 1, 1);
        // extreme corners, feature flag low on a vertex where it is ignored
        offer_vertex(-32768, -32768, 0, 0);
        offer_vertex(32767, -32768, 0, 1);
        offer_vertex(32767, 32767, 1, 1);
        // zero first ring dropped, positive sets the reference, negative is a hole
        offer_vertex(5, -7, 1, 0);
        offer_vertex(0, 0, 0, 1);
        offer_vertex(1, 0, 0, 0);
        offer_vertex(0, 1, 1, 0);
        offer_vertex(100, 100, 0, 0);
        offer_vertex(100, 300, 0, 0);
        offer_vertex(300, 100, 1, 0);
        offer_vertex(-1, 3, 0, 0);
        offer_vertex(-1, 3, 1, 0);
        offer_vertex(-20, -20, 0, 1);
        offer_vertex(40, -20, 0, 1);
        offer_vertex(-20, 40, 1, 1);
        // negative reference: a positive ring is the hole
        offer_vertex(0, 0, 0, 0);
        offer_vertex(0, 9, 0, 0);
        offer_vertex(9, 0, 1, 0);
        offer_vertex(0, 0, 0, 1);
        offer_vertex(9, 0, 0, 1);
        offer_vertex(0, 9, 1, 1);

        // largest edge terms of both signs, second ring a hole of the first
        corner_ring(1'b1, 1'b0);
        corner_ring(1'b0, 1'b1);

        vertex_count = 0;
        while (vertex_count < RANDOM_ITEMS)
        begin
            no_idle = (vertex_count >= 250 && vertex_count < 420);
            if (vertex_count >= 500)
                hold_req = 1'b1;
            if (vertex_count >= 650 && !paused)
            begin
                // drop valid while waiting for every outstanding ring
                in_valid <= 1'b0;
                while (board.pending() != 0)
                    @(posedge clk);
                paused = 1'b1;
            end
            random_feature();
        end
        offer_vertex(pick_coord(), pick_coord(), 1, 1);
        in_valid <= 1'b0;

        // drain outstanding rings, then watch for strays
        waited = 0;
        while (board.pending() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (20) @(posedge clk);
        if (board.pending() != 0)
            board.note_mismatch($sformatf("%0d rings never returned", board.pending()));
        if (board.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Hard stop if the block hangs
    initial
    begin : watchdog
        #30_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
